FILE: design/tps_pkg.sv
`default_nettype none

package tps_pkg;

   // Measurement and register widths
   localparam int DELAY_W     = 24;
   localparam int SPEED_W     = 32;
   localparam int SPEED_FRAC  = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_ANCHORS = 4;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 32'd19647201;

   // Digit size of the pipelined multipliers: one digit of the second operand per stage
   localparam int MUL_DIGIT = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANCHOR_ONE   = 3'd0,
      CSR_ANCHOR_TWO   = 3'd1,
      CSR_ANCHOR_THREE = 3'd2,
      CSR_ANCHOR_FOUR  = 3'd3,
      CSR_WAVE_SPEED   = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

FILE: design/tps_if.sv
`default_nettype none

interface tps_req_if import tps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DELAY_W-1:0] delay_one;
   logic signed [DELAY_W-1:0] delay_two;
   logic signed [DELAY_W-1:0] delay_three;
   logic signed [DELAY_W-1:0] delay_four;

   modport source (output valid, output delay_one, output delay_two,
                   output delay_three, output delay_four, input ready);
   modport sink   (input valid, input delay_one, input delay_two,
                   input delay_three, input delay_four, output ready);
endinterface

interface tps_rsp_if #(
   parameter int COORD_BITS = 20
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic                         fix_valid;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output fix_valid, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input fix_valid, output ready);
endinterface

`default_nettype wire

FILE: design/tps_delay.sv
`default_nettype none

module tps_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [N];

   // advance the whole line on enable
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[N-1];

endmodule

`default_nettype wire

FILE: design/tps_mul.sv
`default_nettype none

module tps_mul import tps_pkg::*; #(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int DIG = MUL_DIGIT;
   localparam int NS  = (WB + DIG - 1) / DIG;
   localparam int BX  = NS * DIG;
   localparam int PW  = WA + WB;

   logic signed [WA-1:0] a_ff   [NS];
   logic signed [BX-1:0] b_ff   [NS];
   logic signed [PW-1:0] acc_ff [NS];
   logic signed [PW-1:0] acc_in [NS];

   // one digit of b per stage; the top digit carries the sign
   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic signed [WA-1:0]    a_src;
      logic signed [BX-1:0]    b_src;
      logic signed [PW-1:0]    acc_src;
      logic signed [DIG:0]     digit;
      logic signed [WA+DIG:0]  part;

      if (i == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = BX'(b);
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[i-1];
         assign b_src   = b_ff[i-1];
         assign acc_src = acc_ff[i-1];
      end

      if (i == NS - 1) begin : g_top
         assign digit = {b_src[DIG*i+DIG-1], b_src[DIG*i +: DIG]};
      end else begin : g_low
         assign digit = {1'b0, b_src[DIG*i +: DIG]};
      end

      assign part      = a_src * digit;
      assign acc_in[i] = acc_src + (PW'(part) <<< (DIG * i));

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[i]   <= a_src;
            b_ff[i]   <= b_src;
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   assign p = acc_ff[NS-1];

endmodule

`default_nettype wire

FILE: design/tps_div.sv
`default_nettype none

module tps_div #(
   parameter int CB = 20,
   parameter int NW = 158,
   parameter int DW = 133
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [CB-1:0] quo,
   output logic                 den_zero
);

   localparam int WW  = NW + 2;
   localparam int MTW = DW + 1;
   localparam logic [CB:0] LIM = (CB+1)'(1) << (CB - 1);
   localparam logic [CB:0] OVF_Q = (CB+1)'(1) << CB;

   // stage A: magnitudes and sign
   logic [NW-1:0] an_ff;
   logic [DW-1:0] ad_ff;
   logic          a_neg_ff, a_dz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff    <= num[NW-1] ? NW'(-num) : NW'(num);
         ad_ff    <= den[DW-1] ? DW'(-den) : DW'(den);
         a_neg_ff <= num[NW-1] ^ den[DW-1];
         a_dz_ff  <= (den == '0);
      end
   end

   // stage B: n = 2|num| + |den|, m = 2|den| gives round half away from zero
   logic [WW-1:0]  n_ff;
   logic [MTW-1:0] m_ff;
   logic           b_neg_ff, b_dz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= WW'({an_ff, 1'b0}) + WW'(ad_ff);
         m_ff     <= {ad_ff, 1'b0};
         b_neg_ff <= a_neg_ff;
         b_dz_ff  <= a_dz_ff;
      end
   end

   // stage C: quotient too large for the coordinate range
   logic [WW-1:0]  c_n_ff;
   logic [MTW-1:0] c_m_ff;
   logic           c_neg_ff, c_dz_ff, c_ovf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c_n_ff   <= n_ff;
         c_m_ff   <= m_ff;
         c_neg_ff <= b_neg_ff;
         c_dz_ff  <= b_dz_ff;
         c_ovf_ff <= (n_ff >= (WW'(m_ff) << CB));
      end
   end

   // restoring stages, one quotient bit each, most significant first
   logic [WW-1:0]  r_ff   [CB];
   logic [CB-1:0]  q_ff   [CB];
   logic [MTW-1:0] m_s_ff [CB];
   logic           neg_ff [CB];
   logic           dz_ff  [CB];
   logic           ovf_ff [CB];

   for (genvar s = 0; s < CB; s++) begin : g_bit
      logic [WW-1:0]  r_src, t;
      logic [CB-1:0]  q_src, q_in;
      logic [MTW-1:0] m_src;
      logic           neg_src, dz_src, ovf_src, ge;

      if (s == 0) begin : g_first
         assign r_src   = c_n_ff;
         assign q_src   = '0;
         assign m_src   = c_m_ff;
         assign neg_src = c_neg_ff;
         assign dz_src  = c_dz_ff;
         assign ovf_src = c_ovf_ff;
      end else begin : g_next
         assign r_src   = r_ff[s-1];
         assign q_src   = q_ff[s-1];
         assign m_src   = m_s_ff[s-1];
         assign neg_src = neg_ff[s-1];
         assign dz_src  = dz_ff[s-1];
         assign ovf_src = ovf_ff[s-1];
      end

      assign t  = WW'(m_src) << (CB - 1 - s);
      assign ge = (r_src >= t);

      always_comb begin
         q_in             = q_src;
         q_in[CB - 1 - s] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= ge ? (r_src - t) : r_src;
            q_ff[s]   <= q_in;
            m_s_ff[s] <= m_src;
            neg_ff[s] <= neg_src;
            dz_ff[s]  <= dz_src;
            ovf_ff[s] <= ovf_src;
         end
      end
   end

   // output stage: saturate, apply sign, zero on a singular system
   logic [CB:0] mag_in, sat_in, res_in;
   logic signed [CB-1:0] quo_ff;
   logic                 den_zero_ff;

   always_comb begin
      mag_in = ovf_ff[CB-1] ? OVF_Q : {1'b0, q_ff[CB-1]};
      if (neg_ff[CB-1]) begin
         sat_in = (mag_in > LIM) ? LIM : mag_in;
         res_in = -sat_in;
      end else begin
         sat_in = (mag_in > LIM - 1'b1) ? (LIM - 1'b1) : mag_in;
         res_in = sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff      <= dz_ff[CB-1] ? '0 : res_in[CB-1:0];
         den_zero_ff <= dz_ff[CB-1];
      end
   end

   assign quo      = quo_ff;
   assign den_zero = den_zero_ff;

endmodule

`default_nettype wire

FILE: design/tps_front.sv
`default_nettype none

module tps_front import tps_pkg::*; #(
   parameter int CB = 20
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [DELAY_W-1:0] delay_in [NUM_ANCHORS],
   input  logic [3*CB-1:0]           anchor   [NUM_ANCHORS],
   input  logic [SPEED_W-1:0]        speed,
   output logic signed [2*CB+3:0]    coef     [3][3],
   output logic signed [3*CB+8:0]    rhs      [3],
   output logic                      range_zero
);

   localparam int PRW  = SPEED_W + DELAY_W + 1;
   localparam int RNDW = PRW - SPEED_FRAC;
   localparam int DW   = CB + 3;
   localparam int SATW = CB + 2;
   localparam int PMW  = CB + DW;
   localparam int MW   = 2 * CB + 4;
   localparam int SQW  = 2 * CB + 1;
   localparam int DDW  = 2 * DW + 1;
   localparam int T1W  = DDW + DW;
   localparam int T2W  = SQW + DW;
   localparam int RW   = 3 * CB + 9;
   localparam logic [PRW-1:0]  HALF = PRW'(1) << (SPEED_FRAC - 1);
   localparam logic [RNDW-1:0] DLIM = RNDW'((64'd1 << (CB + 2)) - 64'd1);

   logic signed [CB-1:0] pos [NUM_ANCHORS][3];

   always_comb begin
      for (int i = 0; i < NUM_ANCHORS; i++) begin
         for (int k = 0; k < 3; k++) begin
            pos[i][k] = $signed(anchor[i][k*CB +: CB]);
         end
      end
   end

   // F1: speed times delay
   logic signed [SPEED_W:0] spd_s;
   logic signed [PRW-1:0]   prod_ff [NUM_ANCHORS];

   assign spd_s = $signed({1'b0, speed});

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            prod_ff[i] <= spd_s * delay_in[i];
         end
      end
   end

   // F2: round, saturate, restore sign; anchor squares
   logic [PRW-1:0]        mag_in [NUM_ANCHORS];
   logic [RNDW-1:0]       rnd_in [NUM_ANCHORS];
   logic [SATW-1:0]       sat_in [NUM_ANCHORS];
   logic signed [DW-1:0]  d_in   [NUM_ANCHORS];
   logic                  rz_in;
   logic signed [DW-1:0]  d_ff   [NUM_ANCHORS];
   logic signed [2*CB-1:0] sqp_ff [NUM_ANCHORS][3];
   logic                  rz2_ff;

   always_comb begin
      rz_in = 1'b0;
      for (int i = 0; i < NUM_ANCHORS; i++) begin
         mag_in[i] = prod_ff[i][PRW-1] ? PRW'(-prod_ff[i]) : PRW'(prod_ff[i]);
         rnd_in[i] = RNDW'((mag_in[i] + HALF) >> SPEED_FRAC);
         sat_in[i] = (rnd_in[i] > DLIM) ? SATW'(DLIM) : SATW'(rnd_in[i]);
         d_in[i]   = prod_ff[i][PRW-1] ? -$signed({1'b0, sat_in[i]})
                                       :  $signed({1'b0, sat_in[i]});
         rz_in     = rz_in | (sat_in[i] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= d_in;
         rz2_ff <= rz_in;
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            for (int k = 0; k < 3; k++) begin
               sqp_ff[i][k] <= pos[i][k] * pos[i][k];
            end
         end
      end
   end

   // F3: coordinate times range difference, square sums
   logic signed [PMW-1:0] pm_ff [3][3];
   logic signed [PMW-1:0] q_ff  [3][3];
   logic signed [DDW-1:0] dd_ff [3];
   logic signed [DW:0]    dlt_in [3];
   logic signed [SQW-1:0] sq_ff [NUM_ANCHORS];
   logic signed [DW-1:0]  d3_ff [NUM_ANCHORS];
   logic                  rz3_ff;

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         dlt_in[m] = (DW+1)'(d_ff[0]) - (DW+1)'(d_ff[m+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
               pm_ff[m][k] <= pos[m+1][k] * d_ff[0];
               q_ff[m][k]  <= pos[0][k] * d_ff[m+1];
            end
            dd_ff[m] <= dlt_in[m] * d_ff[m+1];
         end
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            sq_ff[i] <= SQW'(sqp_ff[i][0]) + SQW'(sqp_ff[i][1]) + SQW'(sqp_ff[i][2]);
         end
         d3_ff  <= d_ff;
         rz3_ff <= rz2_ff;
      end
   end

   // F4: matrix coefficients and right-side terms
   logic signed [MW-1:0]  coef4_ff [3][3];
   logic signed [T1W-1:0] t1_ff [3];
   logic signed [T2W-1:0] t2_ff [3];
   logic signed [T2W-1:0] t3_ff [3];
   logic                  rz4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
               coef4_ff[m][k] <= (MW'(pm_ff[m][k]) - MW'(q_ff[m][k])) <<< 1;
            end
            t1_ff[m] <= dd_ff[m] * d3_ff[0];
            t2_ff[m] <= sq_ff[m+1] * d3_ff[0];
            t3_ff[m] <= sq_ff[0] * d3_ff[m+1];
         end
         rz4_ff <= rz3_ff;
      end
   end

   // F5: right side sum
   logic signed [MW-1:0] coef_ff [3][3];
   logic signed [RW-1:0] rhs_ff  [3];
   logic                 rz5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff <= coef4_ff;
         for (int m = 0; m < 3; m++) begin
            rhs_ff[m] <= RW'(t1_ff[m]) + RW'(t2_ff[m]) - RW'(t3_ff[m]);
         end
         rz5_ff <= rz4_ff;
      end
   end

   assign coef       = coef_ff;
   assign rhs        = rhs_ff;
   assign range_zero = rz5_ff;

endmodule

`default_nettype wire

FILE: design/tdoa_position_solver.sv
`default_nettype none
// Channel   Dir  Handshake         Word
// req       in   valid / ready     delay_one .. delay_four, signed 24-bit ticks
// rsp       out  valid / ready     pos_x, pos_y, pos_z (COORD_BITS), fix_valid
// csr       in   csr_wr_en         csr_index (0..4), csr_wdata (3*COORD_BITS)
//
// One word enters per cycle unless the pipeline is held; each accepted word leaves as one fix.
// Depth is set by the digit-serial multipliers (16 bits of one operand per stage)
// and the restoring dividers (one quotient bit per stage).
// reset is synchronous, active high: clears the pipeline, output and skid valid bits,
// anchors to zero and wave speed to its reset value; req.ready stays low during reset.
// A stalled output register is backed by one skid register; the pipeline holds only
// once the skid register is full.

module tdoa_position_solver import tps_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   tps_req_if.sink                 req,
   tps_rsp_if.source               rsp,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [3*COORD_BITS-1:0] csr_wdata
);

   localparam int CB   = COORD_BITS;
   localparam int MW   = 2 * CB + 4;     // matrix coefficient
   localparam int CW   = 4 * CB + 8;     // cofactor
   localparam int RW   = 3 * CB + 9;     // right side
   localparam int DETW = 6 * CB + 13;    // determinant
   localparam int NW   = 7 * CB + 18;    // Cramer numerator
   localparam int NSM  = (MW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int NSR  = (RW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int FL   = 5;
   localparam int LC   = NSM + 1;
   localparam int LD   = CB + 4;
   localparam int LAT  = FL + LC + NSR + 1 + LD;
   localparam int ALW  = 3 * MW + 3 * RW;
   localparam int RESW = 3 * CB + 1;

   // ---------------------------------------------------------------- registers
   logic [3*CB-1:0]    anchor_ff [NUM_ANCHORS];
   logic [SPEED_W-1:0] speed_ff;

   // take a write only for a known index; others drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ANCHORS; i++) begin
            anchor_ff[i] <= '0;
         end
         speed_ff <= SPEED_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ANCHOR_ONE:   anchor_ff[0] <= csr_wdata;
            CSR_ANCHOR_TWO:   anchor_ff[1] <= csr_wdata;
            CSR_ANCHOR_THREE: anchor_ff[2] <= csr_wdata;
            CSR_ANCHOR_FOUR:  anchor_ff[3] <= csr_wdata;
            CSR_WAVE_SPEED:   speed_ff     <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Every stage advances together; only a full skid register holds the pipeline.
   logic en;
   logic sk_v_ff, out_v_ff;
   logic [LAT-1:0] v_ff;
   logic last_v;

   assign en        = !sk_v_ff;
   assign req.ready = en && !reset;
   assign last_v    = v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req.valid};
      end
   end

   // ---------------------------------------------------------------- system build
   logic signed [DELAY_W-1:0] dly [NUM_ANCHORS];
   logic signed [MW-1:0]      coef [3][3];
   logic signed [RW-1:0]      rhs  [3];
   logic                      range_zero;

   assign dly[0] = req.delay_one;
   assign dly[1] = req.delay_two;
   assign dly[2] = req.delay_three;
   assign dly[3] = req.delay_four;

   tps_front #(.CB(CB)) u_front (
      .clock      (clock),
      .en         (en),
      .delay_in   (dly),
      .anchor     (anchor_ff),
      .speed      (speed_ff),
      .coef       (coef),
      .rhs        (rhs),
      .range_zero (range_zero)
   );

   // ---------------------------------------------------------------- cofactors
   // Cofactor j = 3*row + col, each as a difference of two 2x2 products.
   logic signed [MW-1:0] cof_a [9][2];
   logic signed [MW-1:0] cof_b [9][2];
   logic signed [CW-1:0] cof_p [9][2];
   logic signed [CW-1:0] cof_ff [9];

   always_comb begin
      cof_a[0][0] = coef[1][1]; cof_b[0][0] = coef[2][2];
      cof_a[0][1] = coef[1][2]; cof_b[0][1] = coef[2][1];
      cof_a[1][0] = coef[1][2]; cof_b[1][0] = coef[2][0];
      cof_a[1][1] = coef[1][0]; cof_b[1][1] = coef[2][2];
      cof_a[2][0] = coef[1][0]; cof_b[2][0] = coef[2][1];
      cof_a[2][1] = coef[1][1]; cof_b[2][1] = coef[2][0];
      cof_a[3][0] = coef[0][2]; cof_b[3][0] = coef[2][1];
      cof_a[3][1] = coef[0][1]; cof_b[3][1] = coef[2][2];
      cof_a[4][0] = coef[0][0]; cof_b[4][0] = coef[2][2];
      cof_a[4][1] = coef[0][2]; cof_b[4][1] = coef[2][0];
      cof_a[5][0] = coef[0][1]; cof_b[5][0] = coef[2][0];
      cof_a[5][1] = coef[0][0]; cof_b[5][1] = coef[2][1];
      cof_a[6][0] = coef[0][1]; cof_b[6][0] = coef[1][2];
      cof_a[6][1] = coef[0][2]; cof_b[6][1] = coef[1][1];
      cof_a[7][0] = coef[0][2]; cof_b[7][0] = coef[1][0];
      cof_a[7][1] = coef[0][0]; cof_b[7][1] = coef[1][2];
      cof_a[8][0] = coef[0][0]; cof_b[8][0] = coef[1][1];
      cof_a[8][1] = coef[0][1]; cof_b[8][1] = coef[1][0];
   end

   for (genvar j = 0; j < 9; j++) begin : g_cof
      for (genvar t = 0; t < 2; t++) begin : g_term
         tps_mul #(.WA(MW), .WB(MW)) u_mul (
            .clock (clock),
            .en    (en),
            .a     (cof_a[j][t]),
            .b     (cof_b[j][t]),
            .p     (cof_p[j][t])
         );
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cof_ff[j] <= cof_p[j][0] - cof_p[j][1];
         end
      end
   end

   // hold the first row and the right side until the cofactors are ready
   logic [ALW-1:0] align_din, align_dout;
   logic signed [MW-1:0] row0_d [3];
   logic signed [RW-1:0] rhs_d  [3];

   assign align_din = {coef[0][0], coef[0][1], coef[0][2], rhs[0], rhs[1], rhs[2]};

   tps_delay #(.W(ALW), .N(LC)) u_align (
      .clock (clock),
      .en    (en),
      .din   (align_din),
      .dout  (align_dout)
   );

   assign row0_d[0] = $signed(align_dout[3*RW + 2*MW +: MW]);
   assign row0_d[1] = $signed(align_dout[3*RW + MW +: MW]);
   assign row0_d[2] = $signed(align_dout[3*RW +: MW]);
   assign rhs_d[0]  = $signed(align_dout[2*RW +: RW]);
   assign rhs_d[1]  = $signed(align_dout[RW +: RW]);
   assign rhs_d[2]  = $signed(align_dout[0 +: RW]);

   // ---------------------------------------------------------------- det and numerators
   // det expands along the first row; numerator c expands along column c.
   logic signed [CW+RW-1:0] det_p [3];
   logic signed [CW+RW-1:0] num_p [3][3];
   logic signed [DETW-1:0]  det_ff;
   logic signed [NW-1:0]    num_ff [3];

   for (genvar k = 0; k < 3; k++) begin : g_det
      tps_mul #(.WA(CW), .WB(RW)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (cof_ff[k]),
         .b     (RW'(row0_d[k])),
         .p     (det_p[k])
      );
   end

   for (genvar c = 0; c < 3; c++) begin : g_numc
      for (genvar i = 0; i < 3; i++) begin : g_numr
         tps_mul #(.WA(CW), .WB(RW)) u_mul (
            .clock (clock),
            .en    (en),
            .a     (cof_ff[3*i + c]),
            .b     (rhs_d[i]),
            .p     (num_p[c][i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= DETW'(det_p[0]) + DETW'(det_p[1]) + DETW'(det_p[2]);
         for (int c = 0; c < 3; c++) begin
            num_ff[c] <= NW'(num_p[c][0]) + NW'(num_p[c][1]) + NW'(num_p[c][2]);
         end
      end
   end

   // ---------------------------------------------------------------- division
   logic signed [CB-1:0] quo [3];
   logic [2:0]           den_zero;
   logic                 rz_d;

   for (genvar c = 0; c < 3; c++) begin : g_div
      tps_div #(.CB(CB), .NW(NW), .DW(DETW)) u_div (
         .clock    (clock),
         .en       (en),
         .num      (num_ff[c]),
         .den      (det_ff),
         .quo      (quo[c]),
         .den_zero (den_zero[c])
      );
   end

   // carry the zero range difference flag down to the divider outputs
   tps_delay #(.W(1), .N(LC + NSR + 1 + LD)) u_rz (
      .clock (clock),
      .en    (en),
      .din   (range_zero),
      .dout  (rz_d)
   );

   logic            fix_in;
   logic [RESW-1:0] res_last;

   assign fix_in   = !(rz_d || (|den_zero));
   assign res_last = fix_in ? {1'b1, quo[2], quo[1], quo[0]} : '0;

   // ---------------------------------------------------------------- output and skid
   logic [RESW-1:0] out_res_ff, sk_res_ff;
   logic            take;

   assign take = !out_v_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (take) begin
         if (sk_v_ff) begin
            out_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            out_v_ff <= last_v;
         end
      end else if (en && last_v) begin
         sk_v_ff <= 1'b1;
      end
   end

   // drain the skid word first; otherwise load straight from the pipeline
   always_ff @(posedge clock) begin
      if (take) begin
         out_res_ff <= sk_v_ff ? sk_res_ff : res_last;
      end else if (en && last_v) begin
         sk_res_ff <= res_last;
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.pos_x     = out_res_ff[0 +: CB];
   assign rsp.pos_y     = out_res_ff[CB +: CB];
   assign rsp.pos_z     = out_res_ff[2*CB +: CB];
   assign rsp.fix_valid = out_res_ff[3*CB];

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid register holds a word while the output register is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp.ready && en && last_v |=> sk_v_ff)
      else $error("word leaving the pipeline under stall was not caught");

   a_no_fix_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.fix_valid |->
         rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.pos_z == '0)
      else $error("word without a fix carries a nonzero position");
`endif

endmodule

`default_nettype wire

FILE: tb/tdoa_position_solver_tb.sv
`timescale 1ns / 1ps

// Expected-fix store with its own solver model: notes accepted delay words,
// predicts the fix they produce and compares each fix that leaves the block.
class fix_scoreboard;
   localparam int CB = 20;
   typedef logic signed [191:0] wide_type;
   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic                 ok;
   } fix_type;

   logic [3*CB-1:0] anchor[4];
   logic [31:0]     speed;
   fix_type         pending_fixes[$];
   int              words_in;
   int              fixes_out;
   int              good_fixes;
   int              mismatches;

   function new();
      foreach (anchor[i]) anchor[i] = '0;
      speed = tps_pkg::SPEED_RESET;
   endfunction

   function void set_register(logic [2:0] idx, logic [3*CB-1:0] value);
      if (idx < 3'd4) anchor[idx] = value;
      else if (idx == 3'd4) speed = value[31:0];
   endfunction

   // Scale a tick count to a range difference in mm, rounded, saturated.
   function logic signed [63:0] range_of(logic signed [23:0] ticks);
      logic signed [63:0] s64, t64, p, rng;
      logic [63:0] mag, r, dlim;
      s64 = {32'b0, speed};
      t64 = ticks;
      p = s64 * t64;
      mag = (p < 0) ? -p : p;
      r = (mag + 64'h8000) >> 16;
      dlim = (64'd1 << (CB + 2)) - 1;
      rng = (r > dlim) ? dlim : r;
      return (p < 0) ? -rng : rng;
   endfunction

   function wide_type det_of(wide_type m[3][3]);
      return m[0][0]*m[1][1]*m[2][2] - m[0][0]*m[1][2]*m[2][1]
           - m[0][1]*m[1][0]*m[2][2] + m[0][1]*m[1][2]*m[2][0]
           + m[0][2]*m[1][0]*m[2][1] - m[0][2]*m[1][1]*m[2][0];
   endfunction

   // Divide, rounding half away from zero, and clamp to the coordinate range.
   function logic signed [CB-1:0] coord_of(wide_type num, wide_type den);
      logic [191:0] an, ad, q, lim;
      logic neg;
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      lim = 192'd1 << (CB - 1);
      if (neg) begin
         if (q > lim) q = lim;
         q = -q;
      end else if (q > lim - 1) begin
         q = lim - 1;
      end
      return q[CB-1:0];
   endfunction

   function void note_word(logic signed [23:0] dl[4]);
      logic signed [63:0] d[4], sq[4], p[4][3];
      wide_type m[3][3], rhs[3], t[3][3], det, num;
      fix_type f;
      logic ok;
      ok = 1'b1;
      f = '0;
      words_in++;
      for (int i = 0; i < 4; i++) begin
         d[i] = range_of(dl[i]);
         if (d[i] == 0) ok = 1'b0;
         sq[i] = 0;
         for (int k = 0; k < 3; k++) begin
            p[i][k] = $signed(anchor[i][k*CB +: CB]);
            sq[i] += p[i][k] * p[i][k];
         end
      end
      if (ok) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++)
               m[i][k] = 2 * p[i+1][k] * d[0] - 2 * p[0][k] * d[i+1];
            rhs[i] = wide_type'(d[0] - d[i+1]) * d[i+1] * d[0]
                   + wide_type'(sq[i+1]) * d[0] - wide_type'(sq[0]) * d[i+1];
         end
         det = det_of(m);
         if (det != 0) begin
            for (int c = 0; c < 3; c++) begin
               for (int i = 0; i < 3; i++)
                  for (int k = 0; k < 3; k++)
                     t[i][k] = (k == c) ? rhs[i] : m[i][k];
               num = det_of(t);
               if (c == 0) f.x = coord_of(num, det);
               else if (c == 1) f.y = coord_of(num, det);
               else f.z = coord_of(num, det);
            end
            f.ok = 1'b1;
         end
      end
      pending_fixes.push_back(f);
   endfunction

   function void check_fix(fix_type got);
      fix_type want;
      fixes_out++;
      if (pending_fixes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected fix %0d %0d %0d %0b",
                                        got.x, got.y, got.z, got.ok);
         return;
      end
      want = pending_fixes.pop_front();
      if (want.ok) good_fixes++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("fix %0d: expected %0d %0d %0d valid %0b, got %0d %0d %0d valid %0b",
                     fixes_out, want.x, want.y, want.z, want.ok,
                     got.x, got.y, got.z, got.ok);
      end
   endfunction
endclass

module tdoa_position_solver_tb;
   import tps_pkg::*;

   localparam int CB = 20;
   // unused register slot: writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd5;

   typedef enum {FLOW, CHOPPY, HOLD} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [3*CB-1:0] csr_wdata = '0;

   tps_req_if req ();
   tps_rsp_if #(.COORD_BITS(CB)) rsp ();

   tdoa_position_solver #(.COORD_BITS(CB)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fix_scoreboard board = new();
   int burst_left = 0;
   sink_mode_type sink_mode = FLOW;
   int mode_left = 0;

   always #6 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.delay_one = '0;
      req.delay_two = '0;
      req.delay_three = '0;
      req.delay_four = '0;
      rsp.ready = 1'b0;
   end

   // Receiver: switch between free flow, random stalls and long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            board.check_fix('{rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.fix_valid});
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 2));
            mode_left = (sink_mode == HOLD) ? $urandom_range(1, 20)
                                            : $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (sink_mode)
            FLOW:    rsp.ready <= 1'b1;
            CHOPPY:  rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= 1'b0;
         endcase
      end
   end

   // Write one register; only called with no word in flight.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [3*CB-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(idx, value);
   endtask

   // Hold until every expected fix has come, then let the pipe drain.
   task automatic drain();
      while (board.pending_fixes.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // Offer one word; bursts of random length separated by random gaps.
   task automatic send_word(logic signed [23:0] v[4]);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.delay_one <= v[0];
      req.delay_two <= v[1];
      req.delay_three <= v[2];
      req.delay_four <= v[3];
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_word(v);
   endtask

   task automatic idle_req();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   function automatic logic [3*CB-1:0] pack_pos(int x, int y, int z);
      logic [CB-1:0] px, py, pz;
      px = CB'(x);
      py = CB'(y);
      pz = CB'(z);
      return {pz, py, px};
   endfunction

   function automatic logic [3*CB-1:0] rand_anchor(int span, logic flat);
      int x, y, z;
      x = $urandom_range(0, 2 * span) - span;
      y = $urandom_range(0, 2 * span) - span;
      z = flat ? 0 : $urandom_range(0, 2 * span) - span;
      return pack_pos(x, y, z);
   endfunction

   function automatic logic signed [23:0] rand_delay(int span);
      if ($urandom_range(0, 40) == 0) return '0;
      if (span == 0) return 24'($urandom);
      return 24'($urandom_range(0, 2 * span) - span);
   endfunction

   initial begin
      logic [31:0] spd;
      int span, dspan, n;
      logic flat;
      logic signed [23:0] v[4];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: all anchors at the origin, so every system is singular.
      v = '{24'sd100, -24'sd200, 24'sd300, 24'sd400};
      send_word(v);
      v = '{24'sd0, 24'sd5, 24'sd5, 24'sd5};
      send_word(v);
      idle_req();
      drain();

      // Directed: a plain geometry at 1 mm per tick, then the field extremes.
      write_reg(CSR_ANCHOR_ONE, pack_pos(0, 0, 0));
      write_reg(CSR_ANCHOR_TWO, pack_pos(10000, 0, 0));
      write_reg(CSR_ANCHOR_THREE, pack_pos(0, 10000, 0));
      write_reg(CSR_ANCHOR_FOUR, pack_pos(0, 0, 10000));
      write_reg(CSR_WAVE_SPEED, 60'h1_0000);
      write_reg(CSR_SPARE, {60{1'b1}});
      v = '{24'sd1000, 24'sd2000, -24'sd3000, 24'sd1500};
      send_word(v);
      v = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
      send_word(v);
      v = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
      send_word(v);
      for (int i = 0; i < 4; i++) begin
         v = '{24'sd700, -24'sd900, 24'sd1100, 24'sd1300};
         v[i] = '0;
         send_word(v);
      end
      v = '{24'sd1, -24'sd1, 24'sd1, -24'sd1};
      send_word(v);
      v = '{24'sd3, 24'sd2, 24'sd1, 24'sd1};
      send_word(v);
      idle_req();
      drain();

      // Anchors at the corners of the coordinate range, slowest and fastest waves.
      write_reg(CSR_ANCHOR_ONE, pack_pos(-524288, -524288, -524288));
      write_reg(CSR_ANCHOR_TWO, pack_pos(524287, -524288, 524287));
      write_reg(CSR_ANCHOR_THREE, pack_pos(-524288, 524287, 524287));
      write_reg(CSR_ANCHOR_FOUR, pack_pos(524287, 524287, -524288));
      write_reg(CSR_WAVE_SPEED, 60'h1);
      v = '{24'sh7FFFFF, -24'sd40000, 24'sd99999, 24'sh800000};
      send_word(v);
      v = '{24'sd1, 24'sd2, 24'sd3, 24'sd4};
      send_word(v);
      idle_req();
      drain();
      write_reg(CSR_WAVE_SPEED, 60'hFFFF_FFFF);
      v = '{24'sh7FFFFF, 24'sd1, -24'sd1, 24'sh800000};
      send_word(v);
      v = '{24'sd12, -24'sd77, 24'sd5, 24'sd300};
      send_word(v);
      idle_req();
      drain();

      // Random phases: fresh geometry and speed each time, mostly moderate ranges.
      for (int ph = 0; ph < 9; ph++) begin
         span = ($urandom_range(0, 2) == 0) ? 524287 : $urandom_range(100, 60000);
         flat = ($urandom_range(0, 7) == 0);
         write_reg(CSR_ANCHOR_ONE, rand_anchor(span, flat));
         write_reg(CSR_ANCHOR_TWO, rand_anchor(span, flat));
         write_reg(CSR_ANCHOR_THREE, rand_anchor(span, flat));
         write_reg(CSR_ANCHOR_FOUR, rand_anchor(span, flat));
         case (ph % 4)
            0:       spd = 32'h1_0000;
            1:       spd = $urandom;
            2:       spd = $urandom_range(1, 32'h4_0000);
            default: spd = SPEED_RESET;
         endcase
         if (ph == 7) spd = 32'hFFFF_FFFF;
         write_reg(CSR_WAVE_SPEED, {28'b0, spd});
         n = 205;
         for (int j = 0; j < n; j++) begin
            dspan = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 200000);
            foreach (v[i]) v[i] = rand_delay(dspan);
            send_word(v);
            // hold the sender once until the pipe is empty
            if (ph == 4 && j == 100) begin
               idle_req();
               while (board.pending_fixes.size() != 0) @(posedge clock);
            end
         end
         idle_req();
         drain();
      end

      $display("tb: %0d delay words, %0d fixes checked (%0d valid), %0d mismatches",
               board.words_in, board.fixes_out, board.good_fixes, board.mismatches);
      $display("tb: covered reset, corner and random geometries over slow to fast waves");
      if (board.mismatches == 0 && board.pending_fixes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
